/* hdl/sfadd_pkg.sv */
// Package for the single-precision add/subtract pipeline.
// Holds field widths and the pipeline stage record types; no dependencies.
package sfadd_pkg;

  localparam int unsigned ExpW  = 8;
  localparam int unsigned FracW = 23;
  localparam int unsigned WorkW = 28;  // carry, hidden, 23 frac, guard, round, sticky (27 + carry)

  localparam logic [7:0] ExpMax = 8'hFF;

  // Stage 1 -> 2: ordered operands
  typedef struct packed {
    logic        done;     // result already final
    logic [31:0] early;    // final result when done
    logic        sign;
    logic        eff_sub;
    logic [7:0]  el;
    logic [4:0]  shift;
    logic [22:0] fl;
    logic [22:0] fs;
  } s1_t;

  // Stage 2 -> 3: aligned significands
  typedef struct packed {
    logic        done;
    logic [31:0] early;
    logic        sign;
    logic        eff_sub;
    logic [7:0]  el;
    logic [26:0] lw;
    logic [26:0] sw;
  } s2_t;

  // Stage 3 -> 4: raw sum or difference
  typedef struct packed {
    logic        done;
    logic [31:0] early;
    logic        sign;
    logic [7:0]  el;
    logic [27:0] w;
  } s3_t;

  // Stage 4 -> 5: normalized working value
  typedef struct packed {
    logic        done;
    logic [31:0] early;
    logic        sign;
    logic [9:0]  exp;      // signed-ish, biased by working range
    logic [27:0] w;
  } s4_t;

endpackage

/* hdl/single_float_add_sub.sv */
// Single-precision add/subtract, round to nearest even, five-stage pipeline.
// Depends on sfadd_pkg.
// valid_o is registered in step with result_o; both leave the last stage together.
// Throughput: one transaction per cycle; busy stays low, the pipeline never stalls.
// Stages: order/compare, align, add, normalize, round and pack.
// Reset (rst_ni low, asynchronous) clears the valid bits; data registers keep no reset.
// The receiver cannot stall: every strobe on valid_o is taken.
module single_float_add_sub
  import sfadd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        valid_o,
  output logic [31:0] result_o
);

  // The result side never pushes back, so no stage ever holds.
  assign busy = 1'b0;

  logic [4:0] vld_q;
  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  logic [31:0] res_d, res_q;

  // ---------------- Stage 1: flip sign, order by magnitude, screen specials
  always_comb begin
    logic [31:0] b, l, s;
    logic [7:0]  el, es, diff;
    b = operand_b_i ^ {kind_i, 31'd0};
    if (operand_a_i[30:0] >= b[30:0]) begin
      l = operand_a_i;
      s = b;
    end else begin
      l = b;
      s = operand_a_i;
    end
    el = l[30:23];
    es = s[30:23];
    diff = el - es;  // el >= es since magnitudes are ordered
    s1_d.sign    = l[31];
    s1_d.eff_sub = l[31] ^ s[31];
    s1_d.el      = el;
    s1_d.shift   = diff[4:0];
    s1_d.fl      = l[22:0];
    s1_d.fs      = s[22:0];
    s1_d.done    = 1'b1;
    if (diff >= 8'd25 || es == 8'd0) begin
      s1_d.early = l;
    end else if (el == ExpMax) begin
      s1_d.early = {l[31], ExpMax, 23'd0};
    end else begin
      s1_d.done  = 1'b0;
      s1_d.early = l;
    end
  end

  // ---------------- Stage 2: align smaller significand with guard/round/sticky
  always_comb begin
    logic [49:0] ext;
    logic [22:0] lost;
    logic        sticky;
    // ms placed so that shift 0 lands it at bits [26:3] of the upper window
    ext = {1'b1, s1_q.fs, 26'd0} >> s1_q.shift;
    // window: ms << 3 >> shift; the bits below guard/round form sticky
    lost   = ext[22:0];
    sticky = (lost != 23'd0);
    s2_d.done    = s1_q.done;
    s2_d.early   = s1_q.early;
    s2_d.sign    = s1_q.sign;
    s2_d.eff_sub = s1_q.eff_sub;
    s2_d.el      = s1_q.el;
    s2_d.lw      = {1'b1, s1_q.fl, 3'd0};
    s2_d.sw      = {ext[49:24], ext[23] | sticky};
  end

  // ---------------- Stage 3: add or subtract
  always_comb begin
    s3_d.done  = s2_q.done;
    s3_d.early = s2_q.early;
    s3_d.sign  = s2_q.sign;
    s3_d.el    = s2_q.el;
    if (s2_q.eff_sub) begin
      s3_d.w = {1'b0, s2_q.lw} - {1'b0, s2_q.sw};
    end else begin
      s3_d.w = {1'b0, s2_q.lw} + {1'b0, s2_q.sw};
    end
    if (s2_q.eff_sub && s2_q.lw == s2_q.sw && !s2_q.done) begin
      s3_d.done  = 1'b1;
      s3_d.early = {s2_q.sign, 31'd0};
    end
  end

  // ---------------- Stage 4: count leading zeros and shift left
  always_comb begin
    logic [4:0] lz;
    logic       found;
    lz = 5'd0;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && s3_q.w[i]) begin
        found = 1'b1;
        lz = 5'(26 - i);
      end
    end
    s4_d.done  = s3_q.done;
    s4_d.early = s3_q.early;
    s4_d.sign  = s3_q.sign;
    if (s3_q.w[27]) begin
      s4_d.w   = s3_q.w;
      s4_d.exp = {2'd0, s3_q.el};
    end else begin
      s4_d.w   = s3_q.w << lz;
      s4_d.exp = {2'd0, s3_q.el} - {5'd0, lz};
    end
    // underflow while shifting: flush
    if (!s3_q.done && !s3_q.w[27] &&
        ({2'd0, s3_q.el} <= {5'd0, lz})) begin
      s4_d.done  = 1'b1;
      s4_d.early = {s3_q.sign, 31'd0};
    end
  end

  // ---------------- Stage 5: round to nearest even and pack
  always_comb begin
    logic [26:0] w;
    logic [9:0]  e;
    logic [24:0] q;
    e = s4_q.exp;
    w = s4_q.w[26:0];
    if (s4_q.w[27]) begin
      e = e + 10'd1;
      w = {s4_q.w[27:2], s4_q.w[1] | s4_q.w[0]};
    end
    q = {1'b0, w[26:3]};
    if (w[2] && (w[1:0] != 2'd0 || q[0])) begin
      q = q + 25'd1;
    end
    if (q[24]) begin
      e = e + 10'd1;
      q = q >> 1;
    end
    if (s4_q.done) begin
      res_d = s4_q.early;
    end else if (e >= 10'd255) begin
      res_d = {s4_q.sign, ExpMax, 23'd0};
    end else begin
      res_d = {s4_q.sign, e[7:0], q[22:0]};
    end
  end

  // Advance every stage each cycle; valid bits travel alongside.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], start};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    s2_q  <= s2_d;
    s3_q  <= s3_d;
    s4_q  <= s4_d;
    res_q <= res_d;
  end

  assign valid_o  = vld_q[4];
  assign result_o = res_q;

endmodule

/* tb/tb.sv */
// Self-checking testbench for single_float_add_sub (single-precision add/subtract).
// Depends on sfadd_pkg and the single_float_add_sub RTL; drives directed and random
// operations and compares each strobed result with a bit-exact software predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_SUB = 1'b1;
  localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
  localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
  localparam int unsigned NUM_RANDOM = 400;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        kind_i;
  logic [31:0] operand_a_i;
  logic [31:0] operand_b_i;
  logic        valid_o;
  logic [31:0] result_o;

  // Sums still in flight, oldest first.
  logic [31:0] pending_sums[$];
  int unsigned n_errors;

  typedef struct {
    logic        kind;
    logic [31:0] a;
    logic [31:0] b;
    logic        has_exp;  // expected value typed in below
    logic [31:0] exp_val;
  } op_row_t;

  op_row_t directed_ops[$];

  single_float_add_sub u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .kind_i      (kind_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .valid_o     (valid_o),
    .result_o    (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Round a 28-bit working value to a 24-bit significand, nearest even.
  function automatic logic [24:0] round_nearest_even(input logic [27:0] w_in,
                                                     inout int exp_io);
    logic [27:0] w;
    logic [24:0] q;
    w = w_in;
    if (w[27]) begin
      exp_io++;
      w = {1'b0, w[27:2], w[1] | w[0]};
    end
    q = {1'b0, w[26:3]};
    if (w[2] && (w[1:0] != 2'b00 || q[0])) q = q + 25'd1;
    if (q[24]) begin
      exp_io++;
      q = q >> 1;
    end
    return q;
  endfunction

  function automatic logic [31:0] predict_sum(input logic kind, input logic [31:0] a,
                                              input logic [31:0] b_in);
    logic [31:0] b, big, lit, sgn;
    logic [23:0] mb, ml;
    logic [27:0] bw, lw, d;
    logic [24:0] mant;
    int eb, el, exp, shift;
    b = b_in;
    if (kind == KIND_SUB) b = b ^ SIGN_MASK;
    if (a[30:0] >= b[30:0]) begin
      big = a; lit = b;
    end else begin
      big = b; lit = a;
    end
    sgn = big & SIGN_MASK;
    eb = int'(big[30:23]);
    el = int'(lit[30:23]);
    shift = eb - el;
    if (shift >= 25 || el == 0) return big;
    if (eb == 255) return sgn | INF_BITS;
    mb = {1'b1, big[22:0]};
    ml = {1'b1, lit[22:0]};
    bw = {1'b0, mb, 3'b000};
    if (shift >= 3) begin
      lw = 28'((ml >> (shift - 2)) << 1);
      lw[0] = (lit[22:0] & ((23'd1 << (shift - 2)) - 23'd1)) != 0;
    end else begin
      lw = 28'(ml) << (3 - shift);
    end
    exp = eb;
    if (big[31] != lit[31]) begin
      d = bw - lw;
      if (d == 0) return sgn;
      for (int i = 0; i < 27 && !d[26]; i++) begin
        exp--;
        d = d << 1;
      end
      if (exp <= 0) return sgn;
      mant = round_nearest_even(d, exp);
    end else begin
      mant = round_nearest_even(bw + lw, exp);
    end
    if (exp >= 255) return sgn | INF_BITS;
    if (exp <= 0) return sgn;
    return sgn | (32'(exp) << 23) | {9'd0, mant[22:0]};
  endfunction

  function automatic logic [31:0] random_float();
    logic [31:0] v;
    v = $urandom;
    // Bias exponents toward neighbors so operands actually interact.
    case ($urandom_range(0, 9))
      0: v[30:23] = 8'd0;
      1: v[30:23] = 8'd255;
      2: v[30:23] = 8'd254;
      3: v[30:23] = 8'd1;
      default: v[30:23] = 8'($urandom_range(100, 150));
    endcase
    return v;
  endfunction

  // Hand one operation to the block; hold start until the accept edge.
  task automatic send_op(input logic kind, input logic [31:0] a, input logic [31:0] b);
    start       <= 1'b1;
    kind_i      <= kind;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_sums.push_back(predict_sum(kind, a, b));
  endtask

  task automatic idle_gap();
    int unsigned n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: n = 0;
      9: n = $urandom_range(5, 30);
      default: n = $urandom_range(1, 3);
    endcase
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Check each strobed result against the oldest pending prediction.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result_o);
        n_errors++;
      end else begin
        logic [31:0] want;
        want = pending_sums.pop_front();
        if (result_o !== want) begin
          $display("%0t: result mismatch expected %h actual %h", $time, want, result_o);
          n_errors++;
        end
      end
    end
  end

  task automatic add_row(input logic kind, input logic [31:0] a, input logic [31:0] b,
                         input logic has_exp = 1'b0, input logic [31:0] exp_val = '0);
    op_row_t r;
    r.kind = kind; r.a = a; r.b = b; r.has_exp = has_exp; r.exp_val = exp_val;
    directed_ops.push_back(r);
  endtask

  initial begin
    int unsigned guard;
    n_errors    = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    kind_i      = KIND_ADD;
    operand_a_i = '0;
    operand_b_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: extremes, both operations and every special case.
    add_row(KIND_ADD, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h4000_0000);  // 1 + 1
    add_row(KIND_SUB, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h0000_0000);  // cancel, tie
    add_row(KIND_SUB, 32'h4000_0000, 32'h4000_0000, 1'b1, 32'h0000_0000);
    add_row(KIND_ADD, 32'h3F80_0000, 32'hBF80_0000);                       // exact cancel
    add_row(KIND_ADD, 32'h4040_0000, 32'h0000_0000, 1'b1, 32'h4040_0000);  // zero smaller
    add_row(KIND_ADD, 32'h0000_0001, 32'h4040_0000, 1'b1, 32'h4040_0000);  // denormal
    add_row(KIND_ADD, 32'h4B80_0000, 32'h3F80_0000, 1'b1, 32'h4B80_0000);  // wide gap
    add_row(KIND_ADD, 32'h7F80_0000, 32'h3F80_0000, 1'b1, 32'h7F80_0000);  // infinity
    add_row(KIND_ADD, 32'h7FC0_0000, 32'h7F80_0000, 1'b1, 32'h7F80_0000);  // NaN larger
    add_row(KIND_ADD, 32'h7F80_0001, 32'h7F00_0000, 1'b1, 32'h7F80_0000);
    add_row(KIND_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1, 32'h7F80_0000);  // overflow
    add_row(KIND_SUB, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 1'b1, 32'hFF80_0000);
    add_row(KIND_SUB, 32'h0080_0001, 32'h0080_0000);                       // underflow
    add_row(KIND_SUB, 32'h0100_0000, 32'h00FF_FFFF);
    add_row(KIND_ADD, 32'h3F80_0000, 32'h3380_0000);                       // tie to even
    add_row(KIND_ADD, 32'h3F80_0001, 32'h3380_0000);
    add_row(KIND_SUB, 32'h3F80_0000, 32'h3F7F_FFFF);                       // long renormalize
    add_row(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFF80_0000);
    add_row(KIND_SUB, 32'h4B00_0000, 32'hBF80_0000);
    add_row(KIND_ADD, 32'hC000_0000, 32'h3F80_0000);                       // negative larger
    foreach (directed_ops[i]) begin
      if (directed_ops[i].has_exp &&
          predict_sum(directed_ops[i].kind, directed_ops[i].a, directed_ops[i].b)
            !== directed_ops[i].exp_val) begin
        $display("%0t: table row %0d expected %h predictor %h", $time, i,
                 directed_ops[i].exp_val,
                 predict_sum(directed_ops[i].kind, directed_ops[i].a, directed_ops[i].b));
        n_errors++;
      end
      send_op(directed_ops[i].kind, directed_ops[i].a, directed_ops[i].b);
      if (i % 4 == 3) idle_gap();
    end

    // Random part, with back-to-back stretches and gaps of mixed length.
    for (int unsigned k = 0; k < NUM_RANDOM; k++) begin
      logic [31:0] a, b;
      a = random_float();
      b = random_float();
      // Often place the second operand near the first so alignment matters.
      if ($urandom_range(0, 2) == 0) b[30:23] = 8'(a[30:23] + $urandom_range(0, 4)
                                                   - $urandom_range(0, 4));
      send_op(1'($urandom), a, b);
      if (k >= 100 && k < 160) continue;
      idle_gap();
    end
    start <= 1'b0;

    // Drain the pipeline.
    guard = 0;
    while (pending_sums.size() != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0 && pending_sums.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
hdl/sfadd_pkg.sv
hdl/single_float_add_sub.sv
tb/tb.sv
